FILE: sv/h264_nal_unit_reframer_macros.svh
// Assertion macros for the H.264 NAL unit reframer.
// Included by modules that check their own logic; expects clk_i and rst_ni in scope.
`ifndef H264_NAL_UNIT_REFRAMER_MACROS_SVH
`define H264_NAL_UNIT_REFRAMER_MACROS_SVH

// Check that an implication holds at every clock edge out of reset.
`define H264NR_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never occurs out of reset.
`define H264NR_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

FILE: sv/h264nr_pkg.sv
// Shared types and constants for the H.264 NAL unit reframer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package h264nr_pkg;

  localparam logic FmtAnnexB = 1'b0;
  localparam logic FmtAvcc   = 1'b1;

  localparam logic [4:0] NalTypeIdr = 5'd5;

  localparam int unsigned QueueDepthDefault = 4;

  // m_axis_tuser bit positions
  localparam int unsigned UserByteValid  = 0;
  localparam int unsigned UserUnitDone   = 1;
  localparam int unsigned UserIdrFound   = 2;
  localparam int unsigned UserParseError = 3;
  localparam int unsigned UserWidth      = 4;

  // One input byte's worth of output work: optional start code, then up to four bytes.
  typedef struct packed {
    logic [3:0][7:0] bytes;   // bytes[0] goes out first
    logic [2:0]      n;       // payload byte count, 0..4
    logic            prefix;  // start code precedes bytes[0]
    logic            done;    // last byte of the access unit
    logic            idr;
    logic            err;
  } rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

FILE: sv/h264nr_front.sv
// Front end: parses Annex B or AVCC bytes and classifies each into an output record.
// Depends on h264nr_pkg.
`timescale 1ns / 1ps

module h264nr_front import h264nr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_fmt_i,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       push_o,
  output rec_t       rec_o
);

  logic        fmt_q, fmt_d;
  logic [23:0] la_q, la_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        in_unit_q, in_unit_d;
  logic        head_q, head_d;
  logic [23:0] ls_q, ls_d;
  logic [1:0]  idx_q, idx_d;
  logic [31:0] left_q, left_d;
  logic        idr_q, idr_d;
  logic        unc_q, unc_d;
  logic        err_q, err_d;

  always_comb begin
    logic            accept;
    logic            sc;
    logic            prefix;
    logic            set_head;
    logic            set_err;
    logic [2:0]      n;
    logic [3:0][7:0] bytes;
    logic [31:0]     full_len;

    fmt_d     = fmt_q;
    la_d      = la_q;
    cnt_d     = cnt_q;
    in_unit_d = in_unit_q;
    head_d    = head_q;
    ls_d      = ls_q;
    idx_d     = idx_q;
    left_d    = left_q;
    idr_d     = idr_q;
    unc_d     = unc_q;
    err_d     = err_q;
    push_o    = 1'b0;
    rec_o     = '0;

    accept   = in_valid_i && in_ready_i;
    sc       = 1'b0;
    set_head = 1'b0;
    set_err  = 1'b0;
    n        = 3'd0;
    bytes    = '0;
    full_len = {ls_q, in_byte_i};

    if (fmt_q == FmtAnnexB) begin
      sc = (in_byte_i == 8'h01) && (cnt_q >= 2'd2) && (la_q[15:0] == 16'h0000);
      if (sc) begin
        if ((cnt_q == 2'd3) && (la_q[23:16] != 8'h00) && in_unit_q) begin
          n        = 3'd1;
          bytes[0] = la_q[23:16];
        end
        la_d      = '0;
        cnt_d     = 2'd0;
        in_unit_d = 1'b1;
        set_head  = 1'b1;
      end else begin
        la_d  = {la_q[15:0], in_byte_i};
        cnt_d = (cnt_q == 2'd3) ? 2'd3 : cnt_q + 2'd1;
        if (in_last_i && in_unit_q) begin
          case (cnt_q)
            2'd0: begin
              n     = 3'd1;
              bytes = {24'h000000, in_byte_i};
            end
            2'd1: begin
              n     = 3'd2;
              bytes = {16'h0000, in_byte_i, la_q[7:0]};
            end
            2'd2: begin
              n     = 3'd3;
              bytes = {8'h00, in_byte_i, la_q[7:0], la_q[15:8]};
            end
            default: begin
              n     = 3'd4;
              bytes = {in_byte_i, la_q[7:0], la_q[15:8], la_q[23:16]};
            end
          endcase
        end else if ((cnt_q == 2'd3) && in_unit_q) begin
          n        = 3'd1;
          bytes[0] = la_q[23:16];
        end
      end
    end else begin
      if (!err_q) begin
        if (left_q == 32'd0) begin
          idx_d = idx_q + 2'd1;
          if (idx_q == 2'd3) begin
            if (full_len == 32'd0) begin
              set_err = 1'b1;
            end else begin
              left_d   = full_len;
              set_head = 1'b1;
            end
            ls_d = '0;
          end else begin
            ls_d = full_len[23:0];
          end
        end else begin
          n        = 3'd1;
          bytes[0] = in_byte_i;
          left_d   = left_q - 32'd1;
        end
      end
      if (in_last_i && ((left_d != 32'd0) || (idx_d != 2'd0))) begin
        set_err = 1'b1;
      end
    end

    prefix = head_q && (n != 3'd0);
    head_d = set_head ? 1'b1 : (prefix ? 1'b0 : head_q);
    idr_d  = idr_q | (prefix && (bytes[0][4:0] == NalTypeIdr));
    unc_d  = unc_q | prefix;
    err_d  = err_q | set_err;

    rec_o.bytes  = bytes;
    rec_o.n      = n;
    rec_o.prefix = prefix;
    rec_o.done   = in_last_i;
    rec_o.idr    = idr_d;
    rec_o.err    = err_d || !unc_d;
    push_o       = accept && ((n != 3'd0) || in_last_i);

    if (!accept || in_last_i || cfg_we_i) begin
      if (!accept && !cfg_we_i) begin
        la_d      = la_q;
        cnt_d     = cnt_q;
        in_unit_d = in_unit_q;
        head_d    = head_q;
        ls_d      = ls_q;
        idx_d     = idx_q;
        left_d    = left_q;
        idr_d     = idr_q;
        unc_d     = unc_q;
        err_d     = err_q;
      end else begin
        la_d      = '0;
        cnt_d     = 2'd0;
        in_unit_d = 1'b0;
        head_d    = 1'b0;
        ls_d      = '0;
        idx_d     = 2'd0;
        left_d    = '0;
        idr_d     = 1'b0;
        unc_d     = 1'b0;
        err_d     = 1'b0;
      end
    end
    if (cfg_we_i) begin
      fmt_d = cfg_fmt_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q     <= FmtAnnexB;
      la_q      <= '0;
      cnt_q     <= 2'd0;
      in_unit_q <= 1'b0;
      head_q    <= 1'b0;
      ls_q      <= '0;
      idx_q     <= 2'd0;
      left_q    <= '0;
      idr_q     <= 1'b0;
      unc_q     <= 1'b0;
      err_q     <= 1'b0;
    end else begin
      fmt_q     <= fmt_d;
      la_q      <= la_d;
      cnt_q     <= cnt_d;
      in_unit_q <= in_unit_d;
      head_q    <= head_d;
      ls_q      <= ls_d;
      idx_q     <= idx_d;
      left_q    <= left_d;
      idr_q     <= idr_d;
      unc_q     <= unc_d;
      err_q     <= err_d;
    end
  end

endmodule

FILE: sv/h264nr_fifo.sv
// Record queue between front end and back end.
// Depends on h264nr_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "h264_nal_unit_reframer_macros.svh"

module h264nr_fifo import h264nr_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  rec_t       wr_data_i,
  input  logic       pop_i,
  output rec_t       rd_data_o,
  output fifo_stat_t stat_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  rec_t             mem [Depth];
  logic [AddrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AddrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;

  assign stat_o.full  = (count_q == CntW'(Depth));
  assign stat_o.empty = (count_q == '0);
  assign rd_data_o    = mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == AddrW'(Depth - 1)) ? '0 : wr_ptr_q + AddrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == AddrW'(Depth - 1)) ? '0 : rd_ptr_q + AddrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  `H264NR_NEVER(a_no_push_full, push_i && stat_o.full, "record pushed into full queue")
  `H264NR_NEVER(a_no_pop_empty, pop_i && stat_o.empty, "record popped from empty queue")

endmodule

FILE: sv/h264nr_back.sv
// Back end: expands queued records into output bytes, one transfer per cycle unless m_axis stalls.
// Depends on h264nr_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "h264_nal_unit_reframer_macros.svh"

module h264nr_back import h264nr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rec_t                 rec_i,
  input  fifo_stat_t           stat_i,
  output logic                 pop_o,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [7:0]           m_axis_tdata,
  output logic                 m_axis_tlast,
  output logic [UserWidth-1:0] m_axis_tuser
);

  logic                 valid_q, valid_d;
  logic [2:0]           idx_q, idx_d;
  logic [7:0]           data_q, data_d;
  logic                 last_q, last_d;
  logic [UserWidth-1:0] user_q, user_d;

  always_comb begin
    logic       load;
    logic [2:0] plen;
    logic [2:0] nm1;
    logic [2:0] last_idx;
    logic [2:0] j;
    logic       rec_last;
    logic       in_prefix;

    plen      = rec_i.prefix ? 3'd4 : 3'd0;
    nm1       = (rec_i.n == 3'd0) ? 3'd0 : rec_i.n - 3'd1;
    last_idx  = plen + nm1;
    rec_last  = (idx_q == last_idx);
    in_prefix = (idx_q < plen);
    j         = idx_q - plen;
    load      = !stat_i.empty && (!valid_q || m_axis_tready);

    valid_d = valid_q;
    idx_d   = idx_q;
    data_d  = data_q;
    last_d  = last_q;
    user_d  = user_q;
    pop_o   = 1'b0;

    if (load) begin
      valid_d = 1'b1;
      if (in_prefix) begin
        data_d = (idx_q == 3'd3) ? 8'h01 : 8'h00;
      end else if (rec_i.n == 3'd0) begin
        data_d = 8'h00;
      end else begin
        data_d = rec_i.bytes[j[1:0]];
      end
      last_d                 = rec_last;
      user_d[UserByteValid]  = in_prefix || (rec_i.n != 3'd0);
      user_d[UserUnitDone]   = rec_i.done && rec_last;
      user_d[UserIdrFound]   = rec_i.done && rec_last && rec_i.idr;
      user_d[UserParseError] = rec_i.done && rec_last && rec_i.err;
      if (rec_last) begin
        pop_o = 1'b1;
        idx_d = 3'd0;
      end else begin
        idx_d = idx_q + 3'd1;
      end
    end else if (m_axis_tready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 3'd0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    last_q <= last_d;
    user_q <= user_d;
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = data_q;
  assign m_axis_tlast  = last_q;
  assign m_axis_tuser  = user_q;

  `H264NR_ASSERT(a_done_is_last, (valid_q && user_q[UserUnitDone]) |-> last_q,
                 "unit done flagged before last transfer of its byte")
  `H264NR_ASSERT(a_status_only_done,
                 (valid_q && !user_q[UserByteValid]) |-> (user_q[UserUnitDone] && data_q == 8'h00),
                 "status-only transfer outside the end of an access unit")

endmodule

FILE: sv/h264_nal_unit_reframer.sv
// Top level of the H.264 NAL unit reframer: front end, record queue, back end.
// Depends on h264nr_pkg, h264nr_front, h264nr_fifo and h264nr_back.
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+--------------------------------------
//  s_axis   | in        | s_axis_tvalid/tready    | tdata in_byte, tlast final_byte
//  m_axis   | out       | m_axis_tvalid/tready    | tdata out_byte, tlast run_last, tuser
//  cfg      | in        | cfg_valid_i/cfg_ready_o | cfg_data_i input_format
//
// One input byte is taken per cycle while the queue has room; the back end sends one
// output byte per cycle while m_axis_tready is high; an item becomes its payload bytes
// plus a four-byte start code for each unit it opens. The back end's single output
// register drives m_axis. Reset is asynchronous and clears all control state and sets
// input_format to Annex B. Output stalls back up through a QueueDepth-record queue.
`timescale 1ns / 1ps

module h264_nal_unit_reframer import h264nr_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic                 cfg_data_i,     // input_format
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,   // [7:0] in_byte
  input  logic                 s_axis_tlast,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [7:0]           m_axis_tdata,   // [7:0] out_byte
  output logic                 m_axis_tlast,
  // [0] byte_valid, [1] unit_done, [2] idr_found, [3] parse_error
  output logic [UserWidth-1:0] m_axis_tuser
);

  logic       push;
  logic       pop;
  rec_t       wr_rec;
  rec_t       rd_rec;
  fifo_stat_t stat;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !stat.full;

  h264nr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_fmt_i  (cfg_data_i),
    .in_valid_i (s_axis_tvalid),
    .in_ready_i (s_axis_tready),
    .in_byte_i  (s_axis_tdata),
    .in_last_i  (s_axis_tlast),
    .push_o     (push),
    .rec_o      (wr_rec)
  );

  h264nr_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .wr_data_i (wr_rec),
    .pop_i     (pop),
    .rd_data_o (rd_rec),
    .stat_o    (stat)
  );

  h264nr_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rec_i         (rd_rec),
    .stat_i        (stat),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule
